FILE: design/gdr_pkg.sv
// Package for the Gregorian date register: types, action codes and calendar functions.
// Used by gdr_roll_unit and gregorian_date_register_core; depends on nothing else.
package gdr_pkg;

    // Action codes carried by the input transaction.
    localparam logic [2:0] ACT_SET_DATE  = 3'd0;
    localparam logic [2:0] ACT_SET_MONTH = 3'd1;
    localparam logic [2:0] ACT_SET_DAY   = 3'd2;
    localparam logic [2:0] ACT_SET_YEAR  = 3'd3;
    localparam logic [2:0] ACT_ADD_DAYS  = 3'd4;

    // Calendar constants.
    localparam logic [3:0]  MONTH_FIRST  = 4'd1;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;
    localparam logic [15:0] YEAR_RESET   = 16'd1900;
    localparam logic [8:0]  YEAR_LEN     = 9'd365;
    localparam logic [8:0]  YEAR_LEN_LP  = 9'd366;

    // Multiplicative inverse of 25 modulo 2**16, and the largest quotient y / 25.
    // A 16-bit y is a multiple of 25 exactly when y * INV25 (mod 2**16) <= DIV25_MAX.
    localparam logic [15:0] INV25        = 16'd23593;
    localparam logic [15:0] DIV25_MAX    = 16'd2621;

    // Working day count: day of month plus the signed delta.
    localparam int unsigned WDAY_W = 14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP,
        ST_CHECK,
        ST_ROLL,
        ST_DONE
    } t_state;

    // One step of the month roll, handed from the roll unit to the sequencer.
    typedef struct packed {
        logic [3:0]               month;
        logic signed [WDAY_W-1:0] day;
        logic [15:0]              year;
        logic                     year_step;
        logic                     settled;
    } t_roll;

    // Leap rule: divisible by 4, and not by 100 unless by 400 (400 = 16 * 25).
    function automatic logic gdr_is_leap(input logic [15:0] y);
        logic [15:0] p;
        logic        div25;
        begin
            p     = y * INV25;
            div25 = (p <= DIV25_MAX);
            return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
        end
    endfunction

    // Days in a month; zero for a month code outside 1..12.
    function automatic logic [4:0] gdr_month_len(input logic [3:0] m, input logic leap);
        begin
            unique case (m)
                4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
                4'd2: return leap ? 5'd29 : 5'd28;
                default: return 5'd0;
            endcase
        end
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [8:0] gdr_days_before(input logic [3:0] m);
        begin
            unique case (m)
                4'd1:    return 9'd0;
                4'd2:    return 9'd31;
                4'd3:    return 9'd59;
                4'd4:    return 9'd90;
                4'd5:    return 9'd120;
                4'd6:    return 9'd151;
                4'd7:    return 9'd181;
                4'd8:    return 9'd212;
                4'd9:    return 9'd243;
                4'd10:   return 9'd273;
                4'd11:   return 9'd304;
                4'd12:   return 9'd334;
                default: return 9'd0;
            endcase
        end
    endfunction

endpackage

FILE: design/gdr_roll_unit.sv
// Compare and add unit: one month step of the day roll, forward or backward.
// Depends on gdr_pkg for the month length table and the t_roll result type.
module gdr_roll_unit
    import gdr_pkg::*;
(
    input  logic [3:0]               i_month,
    input  logic signed [WDAY_W-1:0] i_day,
    input  logic [15:0]              i_year,
    input  logic                     i_leap,
    output t_roll                    o_roll
);

    logic [3:0]               m_prev;
    logic signed [WDAY_W-1:0] len_cur;
    logic signed [WDAY_W-1:0] len_prev;
    logic signed [WDAY_W-1:0] day_one;

    // Lengths of this month and of the one before, in the working year.
    always_comb begin
        m_prev   = (i_month <= MONTH_FIRST) ? MONTH_LAST : (i_month - 4'd1);
        len_cur  = signed'({{(WDAY_W-5){1'b0}}, gdr_month_len(i_month, i_leap)});
        len_prev = signed'({{(WDAY_W-5){1'b0}}, gdr_month_len(m_prev, i_leap)});
        day_one  = signed'({{(WDAY_W-5){1'b0}}, DAY_FIRST});
    end

    // Step one month toward the range 1..length, or report that the day has settled.
    always_comb begin
        o_roll.month     = i_month;
        o_roll.day       = i_day;
        o_roll.year      = i_year;
        o_roll.year_step = 1'b0;
        o_roll.settled   = 1'b0;
        priority if (i_day > len_cur) begin
            o_roll.day = i_day - len_cur;
            if (i_month >= MONTH_LAST) begin
                o_roll.month     = MONTH_FIRST;
                o_roll.year      = i_year + 16'd1;
                o_roll.year_step = 1'b1;
            end else begin
                o_roll.month = i_month + 4'd1;
            end
        end else if (i_day < day_one) begin
            // The month wraps first; December is 31 days in any year.
            o_roll.month = m_prev;
            o_roll.day   = i_day + len_prev;
            if (i_month <= MONTH_FIRST) begin
                o_roll.year      = i_year - 16'd1;
                o_roll.year_step = 1'b1;
            end
        end else begin
            o_roll.settled = 1'b1;
        end
    end

endmodule

FILE: design/gregorian_date_register_core.sv
// Top level of the Gregorian date register: date store, sequencer and result fields.
// Depends on gdr_pkg and instantiates gdr_roll_unit.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+-----------------------------------------------
//  input    | start, busy             | i_action, i_new_month, i_new_day, i_new_year,
//           |                         | i_day_delta
//  result   | o_valid (one cycle)     | o_cur_month, o_cur_day, o_cur_year, o_leap,
//           |                         | o_month_length, o_days_passed,
//           |                         | o_days_remaining, o_status
//
// A set transaction passes through leap lookup, check and result after acceptance.
// Adding days passes through leap lookup, then one step of the single month-step unit
// per month crossed plus a settling step, a leap lookup per year crossed, and result.
// busy stays high from acceptance through the result cycle.
// Reset (i_rst_n low, synchronous) restores the date 1-1-1900.
// The receiver cannot stall: o_valid is high for exactly one cycle per transaction.
module gregorian_date_register_core
    import gdr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_action,
    input  logic [3:0]         i_new_month,
    input  logic [4:0]         i_new_day,
    input  logic [15:0]        i_new_year,
    input  logic signed [12:0] i_day_delta,
    output logic               o_valid,
    output logic [3:0]         o_cur_month,
    output logic [4:0]         o_cur_day,
    output logic [15:0]        o_cur_year,
    output logic               o_leap,
    output logic [4:0]         o_month_length,
    output logic [8:0]         o_days_passed,
    output logic [8:0]         o_days_remaining,
    output logic               o_status
);

    t_state                   r_state, n_state;
    logic [3:0]               r_month, n_month;
    logic [4:0]               r_day, n_day;
    logic [15:0]              r_year, n_year;
    logic                     r_leap, n_leap;
    logic                     r_status, n_status;
    logic [2:0]               r_act, n_act;
    logic [3:0]               r_wm, n_wm;
    logic signed [WDAY_W-1:0] r_wd, n_wd;
    logic [15:0]              r_wy, n_wy;
    logic                     r_wleap, n_wleap;

    t_roll                    roll;
    logic                     set_ok;
    logic signed [WDAY_W-1:0] day_sum;
    logic signed [WDAY_W-1:0] wlen;
    logic [8:0]               passed;

    gdr_roll_unit u_roll (
        .i_month (r_wm),
        .i_day   (r_wd),
        .i_year  (r_wy),
        .i_leap  (r_wleap),
        .o_roll  (roll)
    );

    // Validity of a set candidate held in the working registers.
    always_comb begin
        wlen   = signed'({{(WDAY_W-5){1'b0}}, gdr_month_len(r_wm, r_wleap)});
        set_ok = (r_wm >= MONTH_FIRST) && (r_wm <= MONTH_LAST)
              && (r_wd >= signed'(WDAY_W'(1))) && (r_wd <= wlen);
        day_sum = signed'({{(WDAY_W-5){1'b0}}, r_day})
                + WDAY_W'(i_day_delta);
    end

    // Sequencer: next state and register updates.
    always_comb begin
        n_state  = r_state;
        n_month  = r_month;
        n_day    = r_day;
        n_year   = r_year;
        n_leap   = r_leap;
        n_status = r_status;
        n_act    = r_act;
        n_wm     = r_wm;
        n_wd     = r_wd;
        n_wy     = r_wy;
        n_wleap  = r_wleap;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_act    = i_action;
                    n_status = 1'b0;
                    n_wm     = r_month;
                    n_wd     = signed'({{(WDAY_W-5){1'b0}}, r_day});
                    n_wy     = r_year;
                    unique case (i_action)
                        ACT_SET_DATE: begin
                            n_wm = i_new_month;
                            n_wd = signed'({{(WDAY_W-5){1'b0}}, i_new_day});
                            n_wy = i_new_year;
                        end
                        ACT_SET_MONTH: n_wm = i_new_month;
                        ACT_SET_DAY:   n_wd = signed'({{(WDAY_W-5){1'b0}}, i_new_day});
                        ACT_SET_YEAR:  n_wy = i_new_year;
                        ACT_ADD_DAYS:  n_wd = day_sum;
                        default:       n_wd = signed'({{(WDAY_W-5){1'b0}}, r_day});
                    endcase
                    n_state = ST_LEAP;
                end
            end
            ST_LEAP: begin
                n_wleap = gdr_is_leap(r_wy);
                n_state = (r_act == ACT_ADD_DAYS) ? ST_ROLL : ST_CHECK;
            end
            ST_CHECK: begin
                if (r_act == ACT_SET_DATE || r_act == ACT_SET_MONTH
                        || r_act == ACT_SET_DAY || r_act == ACT_SET_YEAR) begin
                    if (set_ok) begin
                        n_month = r_wm;
                        n_day   = r_wd[4:0];
                        n_year  = r_wy;
                        n_leap  = r_wleap;
                    end else begin
                        n_status = 1'b1;
                    end
                end
                n_state = ST_DONE;
            end
            ST_ROLL: begin
                if (roll.settled) begin
                    n_month = r_wm;
                    n_day   = r_wd[4:0];
                    n_year  = r_wy;
                    n_leap  = r_wleap;
                    n_state = ST_DONE;
                end else begin
                    n_wm = roll.month;
                    n_wd = roll.day;
                    n_wy = roll.year;
                    // A new year needs its leap flag before the next step.
                    if (roll.year_step) begin
                        n_state = ST_LEAP;
                    end
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and date registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_month  <= MONTH_FIRST;
            r_day    <= DAY_FIRST;
            r_year   <= YEAR_RESET;
            r_leap   <= 1'b0;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_month  <= n_month;
            r_day    <= n_day;
            r_year   <= n_year;
            r_leap   <= n_leap;
            r_status <= n_status;
        end
    end

    // Working registers of the transaction in progress.
    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_wm    <= n_wm;
        r_wd    <= n_wd;
        r_wy    <= n_wy;
        r_wleap <= n_wleap;
    end

    // Result fields, derived from the stored date.
    always_comb begin
        passed = gdr_days_before(r_month)
               + {8'd0, (r_leap && (r_month > 4'd2))}
               + {4'd0, r_day};
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_valid          = (r_state == ST_DONE);
    assign o_cur_month      = r_month;
    assign o_cur_day        = r_day;
    assign o_cur_year       = r_year;
    assign o_leap           = r_leap;
    assign o_month_length   = gdr_month_len(r_month, r_leap);
    assign o_days_passed    = passed;
    assign o_days_remaining = (r_leap ? YEAR_LEN_LP : YEAR_LEN) - passed;
    assign o_status         = r_status;

`ifndef SYNTHESIS
    // An accepted transaction keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted transaction");

    // A result strobe lasts exactly one cycle.
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // The stored leap flag always matches the stored year.
    a_leap_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leap == gdr_is_leap(r_year))
        else $error("stored leap flag out of step with the year");

    // The stored date is always a valid calendar date.
    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= MONTH_FIRST) && (r_month <= MONTH_LAST) && (r_day >= DAY_FIRST)
        && (r_day <= gdr_month_len(r_month, r_leap)))
        else $error("stored date is not a valid date");
`endif

endmodule

FILE: bench/gregorian_date_register_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Gregorian date register core.
// Depends on gdr_pkg and gregorian_date_register_core; holds its own calendar predictor.
module gregorian_date_register_core_tb;
    import gdr_pkg::*;

    // Action codes that the block treats as no operation.
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    localparam int N_RANDOM_CMDS    = 1280;
    localparam int QUIET_TAIL_CMDS  = 150;
    localparam int STALL_LIMIT      = 2000;
    localparam int END_DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS      = 10;

    // One input transaction.
    typedef struct {
        logic [2:0]  action;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] year;
        logic [12:0] delta;
    } t_date_cmd;

    // One result transaction.
    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] year;
        logic        leap;
        logic [4:0]  mlen;
        logic [8:0]  passed;
        logic [8:0]  remaining;
        logic        status;
    } t_date_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_action = '0;
    logic [3:0]         i_new_month = '0;
    logic [4:0]         i_new_day = '0;
    logic [15:0]        i_new_year = '0;
    logic signed [12:0] i_day_delta = '0;
    logic               o_valid;
    logic [3:0]         o_cur_month;
    logic [4:0]         o_cur_day;
    logic [15:0]        o_cur_year;
    logic               o_leap;
    logic [4:0]         o_month_length;
    logic [8:0]         o_days_passed;
    logic [8:0]         o_days_remaining;
    logic               o_status;

    t_date_cmd    pending_cmds[$];
    t_date_result expected_dates[$];
    t_date_cmd    drive_cmd;
    int           total_cmds = 0;
    int           cmds_accepted = 0;
    int           gap_left = 0;
    int           date_errors = 0;
    int           stall_cycles = 0;

    // Calendar state of the predictor.
    int          cal_month = 1;
    int          cal_day = 1;
    logic [15:0] cal_year = YEAR_RESET;

    gregorian_date_register_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_new_month      (i_new_month),
        .i_new_day        (i_new_day),
        .i_new_year       (i_new_year),
        .i_day_delta      (i_day_delta),
        .o_valid          (o_valid),
        .o_cur_month      (o_cur_month),
        .o_cur_day        (o_cur_day),
        .o_cur_year       (o_cur_year),
        .o_leap           (o_leap),
        .o_month_length   (o_month_length),
        .o_days_passed    (o_days_passed),
        .o_days_remaining (o_days_remaining),
        .o_status         (o_status)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Leap rule: divisible by 4, except centuries not divisible by 400.
    function automatic logic year_is_leap(input logic [15:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(input int m, input logic [15:0] y);
        case (m)
            4, 6, 9, 11:              return 30;
            1, 3, 5, 7, 8, 10, 12:    return 31;
            2:                        return year_is_leap(y) ? 29 : 28;
            default:                  return 0;
        endcase
    endfunction

    function automatic logic date_valid(input int m, input int d, input logic [15:0] y);
        if (m < 1 || m > 12) return 1'b0;
        return (d >= 1) && (d <= month_days(m, y));
    endfunction

    // Applies one transaction to the predicted date and builds the expected result.
    task automatic advance_calendar(input t_date_cmd cmd, output t_date_result res);
        int          d;
        int          m;
        int          passed;
        int          ylen;
        logic [15:0] y;
        logic        status;
        status = 1'b0;
        case (cmd.action)
            ACT_SET_DATE: begin
                if (date_valid(cmd.month, cmd.day, cmd.year)) begin
                    cal_month = cmd.month;
                    cal_day   = cmd.day;
                    cal_year  = cmd.year;
                end else begin
                    status = 1'b1;
                end
            end
            ACT_SET_MONTH: begin
                if (date_valid(cmd.month, cal_day, cal_year)) cal_month = cmd.month;
                else status = 1'b1;
            end
            ACT_SET_DAY: begin
                if (date_valid(cal_month, cmd.day, cal_year)) cal_day = cmd.day;
                else status = 1'b1;
            end
            ACT_SET_YEAR: begin
                if (date_valid(cal_month, cal_day, cmd.year)) cal_year = cmd.year;
                else status = 1'b1;
            end
            ACT_ADD_DAYS: begin
                d = cal_day + $signed(cmd.delta);
                m = cal_month;
                y = cal_year;
                // Forward roll, one month at a time; the year wraps at 16 bits.
                while (d > month_days(m, y)) begin
                    d = d - month_days(m, y);
                    m++;
                    if (m > 12) begin
                        m = 1;
                        y = y + 16'd1;
                    end
                end
                // Backward roll steps the month back before adding its length.
                while (d < 1) begin
                    if (m <= 1) begin
                        m = 12;
                        y = y - 16'd1;
                    end else begin
                        m--;
                    end
                    d = d + month_days(m, y);
                end
                cal_month = m;
                cal_day   = d;
                cal_year  = y;
            end
            default: ;
        endcase
        passed = cal_day;
        for (int i = 1; i < cal_month; i++) passed += month_days(i, cal_year);
        ylen = year_is_leap(cal_year) ? 366 : 365;
        res.month     = 4'(cal_month);
        res.day       = 5'(cal_day);
        res.year      = cal_year;
        res.leap      = year_is_leap(cal_year);
        res.mlen      = 5'(month_days(cal_month, cal_year));
        res.passed    = 9'(passed);
        res.remaining = 9'(ylen - passed);
        res.status    = status;
    endtask

    function automatic logic fields_match(input t_date_result want, input t_date_result got);
        return (want.month === got.month) && (want.day === got.day) &&
               (want.year === got.year) && (want.leap === got.leap) &&
               (want.mlen === got.mlen) && (want.passed === got.passed) &&
               (want.remaining === got.remaining) && (want.status === got.status);
    endfunction

    task automatic push_cmd(input logic [2:0] a, input logic [3:0] m, input logic [4:0] d,
                            input logic [15:0] y, input int dv);
        t_date_cmd cmd;
        cmd.action = a;
        cmd.month  = m;
        cmd.day    = d;
        cmd.year   = y;
        cmd.delta  = dv[12:0];
        pending_cmds.push_back(cmd);
    endtask

    // Years biased toward the wrap points and the century rules.
    function automatic logic [15:0] pick_year();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 3));
            2:       return 16'($urandom_range(65532, 65535));
            3:       return 16'($urandom_range(0, 655) * 100);
            4:       return 16'($urandom_range(0, 163) * 400);
            default: return 16'($urandom_range(1900, 2100));
        endcase
    endfunction

    function automatic int pick_delta();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 8191)) - 4096;
            1:       return int'($urandom_range(0, 80)) - 40;
            2:       return int'($urandom_range(0, 800)) - 400;
            default: return $urandom_range(0, 1) ? int'($urandom_range(4000, 4095))
                                                 : -int'($urandom_range(4000, 4096));
        endcase
    endfunction

    // Driver: presents queued transactions and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        t_date_result res;
        logic         accepted;
        logic         start_next;
        int           phase;
        accepted   = start && !busy;
        start_next = start;
        if (accepted) begin
            advance_calendar(drive_cmd, res);
            expected_dates.push_back(res);
            cmds_accepted++;
            // Idle bursts come in phases, with none near the end of the run.
            phase = (cmds_accepted / 64) % 3;
            if (cmds_accepted < total_cmds - QUIET_TAIL_CMDS && phase != 0 &&
                $urandom_range(0, 3) < (phase == 1 ? 1 : 3))
                gap_left = $urandom_range(1, 16);
        end
        if (i_rst_n && !(start && !accepted)) begin
            if (gap_left > 0) begin
                gap_left--;
                start_next = 1'b0;
            end else if (pending_cmds.size() > 0) begin
                drive_cmd   = pending_cmds.pop_front();
                i_action    <= drive_cmd.action;
                i_new_month <= drive_cmd.month;
                i_new_day   <= drive_cmd.day;
                i_new_year  <= drive_cmd.year;
                i_day_delta <= drive_cmd.delta;
                start_next  = 1'b1;
            end else begin
                start_next = 1'b0;
            end
        end
        start <= start_next;
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_date_result want;
        t_date_result got;
        if (i_rst_n && o_valid === 1'b1) begin
            got.month     = o_cur_month;
            got.day       = o_cur_day;
            got.year      = o_cur_year;
            got.leap      = o_leap;
            got.mlen      = o_month_length;
            got.passed    = o_days_passed;
            got.remaining = o_days_remaining;
            got.status    = o_status;
            if (expected_dates.size() == 0) begin
                date_errors++;
                if (date_errors <= MAX_REPORTS)
                    $display("unexpected result at %0t: %0d-%0d-%0d status %0b",
                             $realtime, got.month, got.day, got.year, got.status);
            end else begin
                want = expected_dates.pop_front();
                if (!fields_match(want, got)) begin
                    date_errors++;
                    if (date_errors <= MAX_REPORTS) begin
                        $write("mismatch at %0t: expected %0d-%0d-%0d leap %0b len %0d ",
                               $realtime, want.month, want.day, want.year, want.leap,
                               want.mlen);
                        $write("passed %0d left %0d status %0b, got %0d-%0d-%0d leap %0b ",
                               want.passed, want.remaining, want.status,
                               got.month, got.day, got.year, got.leap);
                        $display("len %0d passed %0d left %0d status %0b",
                                 got.mlen, got.passed, got.remaining, got.status);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid === 1'b1) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_date_cmd   cmd;
        int          kind;
        logic [15:0] y;
        int          m;

        // Directed part: rejected sets, partial sets, leap rules, wraps and extremes.
        push_cmd(ACT_SPARE_FIRST, 4'd0, 5'd0, 16'd0, 0);
        push_cmd(ACT_SET_DATE, 4'd2, 5'd29, 16'd1900, 0);
        push_cmd(ACT_SET_DATE, 4'd2, 5'd29, 16'd2000, 0);
        push_cmd(ACT_SET_DATE, 4'd15, 5'd31, 16'd65535, -1);
        push_cmd(ACT_SET_DATE, 4'd0, 5'd0, 16'd0, 0);
        push_cmd(ACT_SET_DATE, 4'd4, 5'd31, 16'd2001, 0);
        push_cmd(ACT_SET_MONTH, 4'd4, 5'd0, 16'd0, 0);
        push_cmd(ACT_SET_DAY, 4'd0, 5'd31, 16'd0, 0);
        push_cmd(ACT_SET_DAY, 4'd0, 5'd30, 16'd0, 0);
        push_cmd(ACT_SET_MONTH, 4'd2, 5'd0, 16'd0, 0);
        push_cmd(ACT_SET_DAY, 4'd0, 5'd29, 16'd0, 0);
        push_cmd(ACT_SET_MONTH, 4'd2, 5'd0, 16'd0, 0);
        push_cmd(ACT_SET_YEAR, 4'd0, 5'd0, 16'd2100, 0);
        push_cmd(ACT_SET_YEAR, 4'd0, 5'd0, 16'd0, 0);
        push_cmd(ACT_ADD_DAYS, 4'd0, 5'd0, 16'd0, 4095);
        push_cmd(ACT_SET_DATE, 4'd12, 5'd31, 16'd65535, 0);
        push_cmd(ACT_ADD_DAYS, 4'd0, 5'd0, 16'd0, 1);
        push_cmd(ACT_ADD_DAYS, 4'd0, 5'd0, 16'd0, -1);
        push_cmd(ACT_SET_DATE, 4'd3, 5'd1, 16'd2001, 0);
        push_cmd(ACT_ADD_DAYS, 4'd0, 5'd0, 16'd0, -1);
        push_cmd(ACT_ADD_DAYS, 4'd0, 5'd0, 16'd0, -4096);
        push_cmd(ACT_SPARE_LAST, 4'd15, 5'd31, 16'd65535, -1);
        push_cmd(3'(ACT_SPARE_FIRST + 3'd1), 4'd7, 5'd9, 16'd1234, 77);
        push_cmd(ACT_SET_DATE, 4'd1, 5'd1, 16'd0, 0);
        push_cmd(ACT_ADD_DAYS, 4'd0, 5'd0, 16'd0, -4096);

        // Random part: mostly adds and well-formed sets, with noise in every field.
        for (int n = 0; n < N_RANDOM_CMDS; n++) begin
            cmd.action = ACT_SET_DATE;
            cmd.month  = 4'($urandom_range(0, 15));
            cmd.day    = 5'($urandom_range(0, 31));
            cmd.year   = 16'($urandom_range(0, 65535));
            cmd.delta  = 13'($urandom_range(0, 8191));
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                cmd.action = ACT_ADD_DAYS;
                cmd.delta  = 13'(pick_delta());
            end else if (kind < 60) begin
                y = pick_year();
                m = $urandom_range(1, 12);
                cmd.year  = y;
                cmd.month = 4'(m);
                cmd.day   = 5'($urandom_range(1, month_days(m, y)));
            end else if (kind < 65) begin
                // A date at one end of the year range, then a roll that may cross the wrap.
                if ($urandom_range(0, 1)) begin
                    cmd.year  = 16'd65535;
                    cmd.month = 4'd12;
                    cmd.day   = 5'($urandom_range(1, 31));
                end else begin
                    cmd.year  = 16'd0;
                    cmd.month = 4'd1;
                    cmd.day   = 5'($urandom_range(1, 31));
                end
                pending_cmds.push_back(cmd);
                n++;
                cmd.action = ACT_ADD_DAYS;
                cmd.delta  = 13'(pick_delta());
            end else if (kind < 73) begin
                cmd.action = ACT_SET_DATE;
            end else if (kind < 81) begin
                cmd.action = ACT_SET_MONTH;
                if ($urandom_range(0, 9) < 7) cmd.month = 4'($urandom_range(1, 12));
            end else if (kind < 89) begin
                cmd.action = ACT_SET_DAY;
            end else if (kind < 96) begin
                cmd.action = ACT_SET_YEAR;
                cmd.year   = pick_year();
            end else begin
                cmd.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            end
            pending_cmds.push_back(cmd);
        end
        total_cmds = pending_cmds.size();

        // Synchronous reset, held low and then released.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted < total_cmds || expected_dates.size() != 0) @(posedge i_clk);
        repeat (END_DRAIN_CYCLES) @(posedge i_clk);

        if (date_errors == 0 && expected_dates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
